FILE: rtl/shel_pkg.sv
// shared types, constants and codes for the sensor hold emergency latch
package shel_pkg;

  // field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned HoldW  = 14;
  localparam int unsigned LatchW = 6;
  localparam int unsigned HostW  = 8;
  localparam int unsigned ChirpW = 2;
  localparam int unsigned CfgIdxW = 3;

  // hold timers
  localparam int unsigned NumTimers = 7;
  localparam int unsigned TStop  = 0;
  localparam int unsigned TDual  = 1;
  localparam int unsigned TBlue  = 2;
  localparam int unsigned TRed   = 3;
  localparam int unsigned TAccel = 4;
  localparam int unsigned TTilt  = 5;
  localparam int unsigned TPlay  = 6;

  // compiled hold defaults and limits in ms
  localparam logic [HoldW-1:0] SingleLiftDefault = HoldW'(10000);
  localparam logic [HoldW-1:0] DualLiftDefault   = HoldW'(1000);
  localparam logic [HoldW-1:0] TiltDefault       = HoldW'(2500);
  localparam logic [HoldW-1:0] StopDefault       = HoldW'(100);
  localparam logic [HoldW-1:0] ClearDefault      = HoldW'(2000);
  localparam logic [HoldW-1:0] MinTripMs         = HoldW'(10);
  localparam logic [HoldW-1:0] MaxClearMs        = HoldW'(10000);
  localparam logic [TimeW-1:0] AlarmPeriodMs     = TimeW'(5000);

  // latch bit masks
  localparam logic [LatchW-1:0] BitHost   = 6'b000001;
  localparam logic [LatchW-1:0] BitYellow = 6'b000010;
  localparam logic [LatchW-1:0] BitWhite  = 6'b000100;
  localparam logic [LatchW-1:0] BitBlue   = 6'b001000;
  localparam logic [LatchW-1:0] BitRed    = 6'b010000;
  localparam logic [LatchW-1:0] BitTilt   = 6'b100000;

  // input function codes
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_HOST   = 1'b1
  } func_e;

  // buzzer request codes
  typedef enum logic [ChirpW-1:0] {
    CHIRP_NONE  = 2'd0,
    CHIRP_CLEAR = 2'd1,
    CHIRP_ALARM = 2'd2
  } chirp_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SINGLE_LIFT = 3'd0,
    CFG_DUAL_LIFT   = 3'd1,
    CFG_TILT        = 3'd2,
    CFG_STOP        = 3'd3,
    CFG_CLEAR       = 3'd4
  } cfg_idx_e;

  // per-timer control for one transaction
  typedef struct packed {
    logic step;    // a sensor sample advances the timers
    logic active;  // the watched condition holds in this sample
  } timer_ctrl_t;

  // clamp a trip hold to [MinTripMs, dflt]
  function automatic logic [HoldW-1:0] clamp_trip(logic [HoldW-1:0] v,
                                                  logic [HoldW-1:0] dflt);
    logic [HoldW-1:0] r;
    if (v < MinTripMs) begin
      r = MinTripMs;
    end else if (v > dflt) begin
      r = dflt;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // clamp the clear hold to [dflt, MaxClearMs]
  function automatic logic [HoldW-1:0] clamp_clear(logic [HoldW-1:0] v,
                                                   logic [HoldW-1:0] dflt);
    logic [HoldW-1:0] r;
    if (v < dflt) begin
      r = dflt;
    end else if (v > MaxClearMs) begin
      r = MaxClearMs;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/shel_hold_timer.sv
// one hold timer: start tick, running flag and elapsed-time compare
module shel_hold_timer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  shel_pkg::timer_ctrl_t     ctrl_i,
  input  logic [shel_pkg::TimeW-1:0] now_i,
  input  logic [shel_pkg::HoldW-1:0] hold_i,
  output logic                      fire_o
);
  import shel_pkg::*;

  logic             running_q, running_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [TimeW-1:0] elapsed;

  // elapsed time modulo 2^32 against the hold
  assign elapsed = now_i - start_q;
  assign fire_o  = ctrl_i.active & running_q & (elapsed >= TimeW'(hold_i));

  // start on the first asserted sample, stop on a deasserted one
  always_comb begin
    running_d = running_q;
    start_d   = start_q;
    if (ctrl_i.step) begin
      if (!ctrl_i.active) begin
        running_d = 1'b0;
      end else if (!running_q) begin
        running_d = 1'b1;
        start_d   = now_i;
      end
    end
  end

  // running flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
    end else begin
      running_q <= running_d;
    end
  end

  // start tick, only read while running
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
  end

endmodule

FILE: rtl/sensor_hold_emergency_latch_unit.sv
// top level of the sensor hold emergency latch
//
// Usage: sensor samples and host commands arrive on the input channel
// (in_valid_i / in_ready_o), one transaction each; every transaction gives
// exactly one result transaction on the output channel (out_valid_o /
// out_ready_i) carrying the latch, the buzzer request and the cleared flag.
// Hold times are written through cfg_we_i / cfg_idx_i / cfg_data_i while the
// block is idle; written values are clamped, unknown indexes are ignored.
// Between acceptance and output lie the input register and the result
// register: while a transaction sits in the input register, seven parallel
// subtract-and-compare timers, the latch update and the alarm compare settle
// combinationally and load the result register when it is empty or read.
// Throughput is one transaction per cycle while the receiver takes results,
// set by the single pass from input register to result register.
// Reset clears all timers, the latch, the alarm tick and both registers'
// valid flags and restores the default holds.
// When the receiver stalls, the result register holds; the input register
// takes one more transaction, then in_ready_o drops until the result moves.
module sensor_hold_emergency_latch_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [shel_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [shel_pkg::HoldW-1:0]    cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [shel_pkg::TimeW-1:0]    time_ms_i,
  input  logic                          stop_yellow_i,
  input  logic                          stop_white_i,
  input  logic                          lift_blue_i,
  input  logic                          lift_red_i,
  input  logic                          tilt_switch_i,
  input  logic                          accel_low_z_i,
  input  logic                          play_pressed_i,
  input  logic [shel_pkg::HostW-1:0]    host_value_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [shel_pkg::LatchW-1:0]   emergency_bits_o,
  output logic [shel_pkg::ChirpW-1:0]   chirp_o,
  output logic                          cleared_o
);
  import shel_pkg::*;

  // hold registers
  logic [HoldW-1:0] single_hold_q, dual_hold_q, tilt_hold_q, stop_hold_q, clear_hold_q;

  // input register
  logic             in_vld_q;
  logic             func_q;
  logic [TimeW-1:0] time_q;
  logic             yellow_q, white_q, blue_q, red_q, tilt_q, accel_q, play_q;
  logic [HostW-1:0] host_q;

  // result register
  logic              out_vld_q;
  logic [LatchW-1:0] res_bits_q;
  chirp_e            res_chirp_q;
  logic              res_cleared_q;

  // block state
  logic [LatchW-1:0] latch_q, latch_d;
  logic [TimeW-1:0]  alarm_q, alarm_d;

  logic              advance;
  logic              step;
  timer_ctrl_t       tctrl [NumTimers];
  logic [HoldW-1:0]  thold [NumTimers];
  logic              fire  [NumTimers];
  logic [LatchW-1:0] latch_mid;
  chirp_e            chirp_d;
  logic              cleared_d;

  // handshakes
  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;
  assign step       = advance & (func_q == FUNC_SAMPLE);

  // configuration writes with clamping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_hold_q <= SingleLiftDefault;
      dual_hold_q   <= DualLiftDefault;
      tilt_hold_q   <= TiltDefault;
      stop_hold_q   <= StopDefault;
      clear_hold_q  <= ClearDefault;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SINGLE_LIFT: single_hold_q <= clamp_trip(cfg_data_i, SingleLiftDefault);
        CFG_DUAL_LIFT:   dual_hold_q   <= clamp_trip(cfg_data_i, DualLiftDefault);
        CFG_TILT:        tilt_hold_q   <= clamp_trip(cfg_data_i, TiltDefault);
        CFG_STOP:        stop_hold_q   <= clamp_trip(cfg_data_i, StopDefault);
        CFG_CLEAR:       clear_hold_q  <= clamp_clear(cfg_data_i, ClearDefault);
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q   <= func_i;
      time_q   <= time_ms_i;
      yellow_q <= stop_yellow_i;
      white_q  <= stop_white_i;
      blue_q   <= lift_blue_i;
      red_q    <= lift_red_i;
      tilt_q   <= tilt_switch_i;
      accel_q  <= accel_low_z_i;
      play_q   <= play_pressed_i;
      host_q   <= host_value_i;
    end
  end

  // timer conditions and holds
  always_comb begin
    tctrl[TStop]  = '{step: step, active: yellow_q | white_q};
    tctrl[TDual]  = '{step: step, active: blue_q & red_q};
    tctrl[TBlue]  = '{step: step, active: blue_q};
    tctrl[TRed]   = '{step: step, active: red_q};
    tctrl[TAccel] = '{step: step, active: accel_q};
    tctrl[TTilt]  = '{step: step, active: tilt_q};
    tctrl[TPlay]  = '{step: step, active: (latch_mid != '0) & play_q};
    thold[TStop]  = stop_hold_q;
    thold[TDual]  = dual_hold_q;
    thold[TBlue]  = single_hold_q;
    thold[TRed]   = single_hold_q;
    thold[TAccel] = tilt_hold_q;
    thold[TTilt]  = tilt_hold_q;
    thold[TPlay]  = clear_hold_q;
  end

  // hold timers
  for (genvar t = 0; t < NumTimers; t++) begin : g_timer
    shel_hold_timer u_timer (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (tctrl[t]),
      .now_i  (time_q),
      .hold_i (thold[t]),
      .fire_o (fire[t])
    );
  end

  // latch bits set by the sensor timers in this sample
  always_comb begin
    latch_mid = latch_q;
    if (fire[TStop] && yellow_q) latch_mid = latch_mid | BitYellow;
    if (fire[TStop] && white_q)  latch_mid = latch_mid | BitWhite;
    if (fire[TDual])             latch_mid = latch_mid | BitBlue | BitRed;
    if (fire[TBlue])             latch_mid = latch_mid | BitBlue;
    if (fire[TRed])              latch_mid = latch_mid | BitRed;
    if (fire[TAccel] || fire[TTilt]) latch_mid = latch_mid | BitTilt;
  end

  // play clear, alarm chirp and host command
  always_comb begin
    latch_d   = latch_q;
    alarm_d   = alarm_q;
    chirp_d   = CHIRP_NONE;
    cleared_d = 1'b0;
    if (func_q == FUNC_HOST) begin
      latch_d = (host_q != '0) ? BitHost : '0;
    end else begin
      latch_d = latch_mid;
      if (fire[TPlay]) begin
        latch_d   = '0;
        cleared_d = 1'b1;
        chirp_d   = CHIRP_CLEAR;
      end
      if ((latch_d != '0) && ((time_q - alarm_q) > AlarmPeriodMs)) begin
        alarm_d = time_q;
        chirp_d = CHIRP_ALARM;
      end
    end
  end

  // latch and alarm tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
      alarm_q <= '0;
    end else if (advance) begin
      latch_q <= latch_d;
      alarm_q <= alarm_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_bits_q    <= latch_d;
      res_chirp_q   <= chirp_d;
      res_cleared_q <= cleared_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign emergency_bits_o = res_bits_q;
  assign chirp_o          = res_chirp_q;
  assign cleared_o        = res_cleared_q;

endmodule
